// ===== design/particle_cell_list_binning_assert.svh =====
// Assertion macros for the particle cell list binning block.
// Used by the port-level checker; no other dependencies.
`ifndef PARTICLE_CELL_LIST_BINNING_ASSERT_SVH
`define PARTICLE_CELL_LIST_BINNING_ASSERT_SVH

// Same-cycle implication, masked while reset is asserted
`define PLCB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, masked while reset is asserted
`define PLCB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication that also runs through reset
`define PLCB_ASSERT_NEXT_RST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ===== design/plcb_pkg.sv =====
// Shared types and constants for the particle cell list binning block.
// No dependencies; compiled first.
`default_nettype none

package plcb_pkg;

    // Fixed field widths
    localparam int ID_W        = 16;
    localparam int POS_W       = 32;
    localparam int INV_W       = 24;
    localparam int CELLS_REG_W = 5;
    localparam int COORD_OUT_W = 4;
    localparam int SLOT_OUT_W  = 4;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Fixed point: Q.16 difference times Q8.16 reciprocal gives Q.32
    localparam int DIFF_W   = POS_W + 1;
    localparam int PROD_W   = DIFF_W + INV_W + 1;
    localparam int PROD_FRAC = 32;
    localparam int CELL_W   = PROD_W - PROD_FRAC;

    // Register reset values
    localparam logic [POS_W-1:0]       ORIGIN_RST = '0;
    localparam logic [INV_W-1:0]       INV_RST    = 24'd50412;
    localparam logic [CELLS_REG_W-1:0] CELLS_RST  = 5'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X  = 3'd0,
        CFG_ORIGIN_Y  = 3'd1,
        CFG_ORIGIN_Z  = 3'd2,
        CFG_INV_CELL  = 3'd3,
        CFG_CELLS_X   = 3'd4,
        CFG_CELLS_Y   = 3'd5,
        CFG_CELLS_Z   = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_STORED  = 2'd0,
        ST_FULL    = 2'd1,
        ST_OUTSIDE = 2'd2
    } t_status;

    typedef struct packed {
        logic [ID_W-1:0]         particle_index;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } t_in_beat;

    typedef struct packed {
        logic [ID_W-1:0]        particle_id_out;
        logic [COORD_OUT_W-1:0] cell_x;
        logic [COORD_OUT_W-1:0] cell_y;
        logic [COORD_OUT_W-1:0] cell_z;
        logic [SLOT_OUT_W-1:0]  slot;
        t_status                status;
    } t_out_beat;

    // Count memory access strobes
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

endpackage

`default_nettype wire

// ===== design/plcb_in_if.sv =====
// Particle input channel: valid/ready handshake with a t_in_beat payload.
// Depends on plcb_pkg.
`default_nettype none

interface plcb_in_if;
    import plcb_pkg::*;

    logic     valid;
    logic     ready;
    t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/plcb_out_if.sv =====
// Result channel: valid/ready handshake with a t_out_beat payload.
// Depends on plcb_pkg.
`default_nettype none

interface plcb_out_if;
    import plcb_pkg::*;

    logic      valid;
    logic      ready;
    t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/plcb_axis.sv =====
// One axis of the cell index: subtract, multiply, floor plus one, range check.
// Two register stages; depends on plcb_pkg.
`default_nettype none

module plcb_axis #(
    parameter int CELLS_PER_AXIS = 16,
    parameter int AXIS_W         = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [plcb_pkg::POS_W-1:0]    i_pos,
    input  logic signed [plcb_pkg::POS_W-1:0]    i_org,
    input  logic [plcb_pkg::INV_W-1:0]           i_inv,
    input  logic [plcb_pkg::CELLS_REG_W-1:0]     i_cells,
    output logic                                 o_ok,
    output logic [AXIS_W-1:0]                    o_coord
);
    import plcb_pkg::*;

    logic signed [DIFF_W-1:0] r_diff;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [CELL_W-1:0] w_cell;

    // Stage 1: exact difference
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_diff <= DIFF_W'(i_pos) - DIFF_W'(i_org);
        end
    end

    // Stage 2: exact Q.32 product
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= r_diff * $signed({1'b0, i_inv});
        end
    end

    // Upper bits are the floor toward minus infinity; then add one
    assign w_cell = $signed(r_prod[PROD_W-1:PROD_FRAC]) + CELL_W'(1);

    assign o_ok = !w_cell[CELL_W-1]
               && (w_cell[CELL_W-2:0] < (CELL_W-1)'(i_cells))
               && (w_cell[CELL_W-2:0] < (CELL_W-1)'(CELLS_PER_AXIS));
    assign o_coord = w_cell[AXIS_W-1:0];
endmodule

`default_nettype wire

// ===== design/plcb_cnt_mem.sv =====
// Per-cell occupant count memory, one read and one write port, registered read.
// Runs a clearing pass after reset; depends on plcb_pkg.
`default_nettype none

module plcb_cnt_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  plcb_pkg::t_mem_ctl  i_ctl,
    input  logic [AW-1:0]       i_rd_addr,
    output logic [DW-1:0]       o_rd_data,
    input  logic [AW-1:0]       i_wr_addr,
    input  logic [DW-1:0]       i_wr_data,
    output logic                o_busy
);
    import plcb_pkg::*;

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;
    logic          w_we;
    logic [AW-1:0] w_wa;
    logic [DW-1:0] w_wd;

    // Clearing sweep, one entry per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Sweep owns the write port while busy
    always_comb begin
        w_we = r_clr_busy || i_ctl.wr_en;
        w_wa = r_clr_busy ? r_clr_addr : i_wr_addr;
        w_wd = r_clr_busy ? '0 : i_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_clr_busy;
endmodule

`default_nettype wire

// ===== design/plcb_member_mem.sv =====
// Member list store: one write port, indexed by cell and slot.
// No reset contents; depends on nothing.
`default_nettype none

module plcb_member_mem #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data
);
    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end
endmodule

`default_nettype wire

// ===== design/particle_cell_list_binning.sv =====
// Uniform grid cell list binning: top level, config registers and pipeline.
// Depends on plcb_pkg, plcb_in_if, plcb_out_if, plcb_axis, plcb_cnt_mem,
// plcb_member_mem.
//
//  Channel    Dir  Handshake            Beat
//  i_bin      in   valid/ready          particle index, x/y/z position
//  o_res      out  valid/ready          index echo, cell x/y/z, slot, status
//  i_cfg_*    in   write enable only    register index, write data
//
// One particle per cycle sustained while the result is taken; a beat passes the
// difference, product, count read and count update stages to the result register.
// The count read-modify-write forwards the last written count on a same-cell hit.
// After reset a clearing pass zeroes all CELLS_PER_AXIS**3 count entries
// (4096 at defaults); no beat is accepted during the pass.
// When the result is not taken the whole pipeline holds.
`default_nettype none

module particle_cell_list_binning #(
    parameter int MAX_PER_CELL   = 16,
    parameter int CELLS_PER_AXIS = 16,
    parameter int INDEX_BITS     = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [plcb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [plcb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    plcb_in_if.sink                            i_bin,
    plcb_out_if.source                         o_res
);
    import plcb_pkg::*;

    localparam int AXIS_W    = $clog2(CELLS_PER_AXIS);
    localparam int NCELLS    = CELLS_PER_AXIS * CELLS_PER_AXIS * CELLS_PER_AXIS;
    localparam int ADDR_W    = $clog2(NCELLS);
    localparam int CNT_W     = $clog2(MAX_PER_CELL + 1);
    localparam int MEM_DEPTH = NCELLS * MAX_PER_CELL;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    // Configuration registers
    logic signed [POS_W-1:0]  r_origin_x, r_origin_y, r_origin_z;
    logic [INV_W-1:0]         r_inv;
    logic [CELLS_REG_W-1:0]   r_cells_x, r_cells_y, r_cells_z;

    // Pipeline control and payload
    logic                     w_adv;
    logic                     w_clr_busy;
    logic                     r_a_vld, r_b_vld, r_d_vld, r_out_vld;
    logic [ID_W-1:0]          r_a_id, r_b_id, r_d_id;
    logic                     w_ok_x, w_ok_y, w_ok_z;
    logic [AXIS_W-1:0]        w_cx, w_cy, w_cz;
    logic [ADDR_W-1:0]        w_c_addr;
    logic                     r_d_in;
    logic [AXIS_W-1:0]        r_d_cx, r_d_cy, r_d_cz;
    logic [ADDR_W-1:0]        r_d_addr;
    t_out_beat                r_out;

    // Count update
    t_mem_ctl                 w_cnt_ctl;
    logic [CNT_W-1:0]         w_rd_cnt;
    logic [CNT_W-1:0]         w_n;
    logic [CNT_W-1:0]         w_n_inc;
    logic                     w_full;
    logic                     w_store;
    logic [MEM_AW-1:0]        w_mem_addr;
    logic                     r_fwd_vld;
    logic [ADDR_W-1:0]        r_fwd_addr;
    logic [CNT_W-1:0]         r_fwd_cnt;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= ORIGIN_RST;
            r_origin_y <= ORIGIN_RST;
            r_origin_z <= ORIGIN_RST;
            r_inv      <= INV_RST;
            r_cells_x  <= CELLS_RST;
            r_cells_y  <= CELLS_RST;
            r_cells_z  <= CELLS_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ORIGIN_X: r_origin_x <= i_cfg_data;
                CFG_ORIGIN_Y: r_origin_y <= i_cfg_data;
                CFG_ORIGIN_Z: r_origin_z <= i_cfg_data;
                CFG_INV_CELL: r_inv      <= i_cfg_data[INV_W-1:0];
                CFG_CELLS_X:  r_cells_x  <= i_cfg_data[CELLS_REG_W-1:0];
                CFG_CELLS_Y:  r_cells_y  <= i_cfg_data[CELLS_REG_W-1:0];
                CFG_CELLS_Z:  r_cells_z  <= i_cfg_data[CELLS_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // Global advance: result register free or being drained
    assign w_adv       = !r_out_vld || o_res.ready;
    assign i_bin.ready = w_adv && !w_clr_busy;

    // Per-axis arithmetic, stages A and B
    plcb_axis #(.CELLS_PER_AXIS(CELLS_PER_AXIS), .AXIS_W(AXIS_W)) u_axis_x (
        .i_clk(i_clk), .i_en(w_adv), .i_pos(i_bin.data.pos_x), .i_org(r_origin_x),
        .i_inv(r_inv), .i_cells(r_cells_x), .o_ok(w_ok_x), .o_coord(w_cx)
    );
    plcb_axis #(.CELLS_PER_AXIS(CELLS_PER_AXIS), .AXIS_W(AXIS_W)) u_axis_y (
        .i_clk(i_clk), .i_en(w_adv), .i_pos(i_bin.data.pos_y), .i_org(r_origin_y),
        .i_inv(r_inv), .i_cells(r_cells_y), .o_ok(w_ok_y), .o_coord(w_cy)
    );
    plcb_axis #(.CELLS_PER_AXIS(CELLS_PER_AXIS), .AXIS_W(AXIS_W)) u_axis_z (
        .i_clk(i_clk), .i_en(w_adv), .i_pos(i_bin.data.pos_z), .i_org(r_origin_z),
        .i_inv(r_inv), .i_cells(r_cells_z), .o_ok(w_ok_z), .o_coord(w_cz)
    );

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_d_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_a_vld   <= i_bin.valid && !w_clr_busy;
            r_b_vld   <= r_a_vld;
            r_d_vld   <= r_b_vld;
            r_out_vld <= r_d_vld;
        end
    end

    // Stage C: cell address, count read issued here
    assign w_c_addr = (ADDR_W'(w_cx) * ADDR_W'(CELLS_PER_AXIS) + ADDR_W'(w_cy))
                      * ADDR_W'(CELLS_PER_AXIS) + ADDR_W'(w_cz);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_id   <= i_bin.data.particle_index;
            r_b_id   <= r_a_id;
            r_d_id   <= r_b_id;
            r_d_in   <= w_ok_x && w_ok_y && w_ok_z;
            r_d_cx   <= w_cx;
            r_d_cy   <= w_cy;
            r_d_cz   <= w_cz;
            r_d_addr <= w_c_addr;
        end
    end

    // Stage D: count with forwarding of the last write
    always_comb begin
        w_n        = (r_fwd_vld && r_fwd_addr == r_d_addr) ? r_fwd_cnt : w_rd_cnt;
        w_full     = w_n >= CNT_W'(MAX_PER_CELL);
        w_n_inc    = w_n + CNT_W'(1);
        w_store    = w_adv && r_d_vld && r_d_in && !w_full;
        w_mem_addr = MEM_AW'(r_d_addr) * MEM_AW'(MAX_PER_CELL) + MEM_AW'(w_n);
        w_cnt_ctl.rd_en = w_adv;
        w_cnt_ctl.wr_en = w_store;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_vld <= 1'b0;
        end else if (w_store) begin
            r_fwd_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_fwd_addr <= r_d_addr;
            r_fwd_cnt  <= w_n_inc;
        end
    end

    plcb_cnt_mem #(.DEPTH(NCELLS), .AW(ADDR_W), .DW(CNT_W)) u_cnt_mem (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_cnt_ctl),
        .i_rd_addr(w_c_addr), .o_rd_data(w_rd_cnt),
        .i_wr_addr(r_d_addr), .i_wr_data(w_n_inc), .o_busy(w_clr_busy)
    );

    plcb_member_mem #(.DEPTH(MEM_DEPTH), .AW(MEM_AW), .DW(INDEX_BITS)) u_member_mem (
        .i_clk(i_clk), .i_wr_en(w_store), .i_wr_addr(w_mem_addr),
        .i_wr_data(INDEX_BITS'(r_d_id))
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out.particle_id_out <= r_d_id;
            if (!r_d_in) begin
                r_out.cell_x <= '0;
                r_out.cell_y <= '0;
                r_out.cell_z <= '0;
                r_out.slot   <= '0;
                r_out.status <= ST_OUTSIDE;
            end else begin
                r_out.cell_x <= COORD_OUT_W'(r_d_cx);
                r_out.cell_y <= COORD_OUT_W'(r_d_cy);
                r_out.cell_z <= COORD_OUT_W'(r_d_cz);
                r_out.slot   <= w_full ? '0 : SLOT_OUT_W'(w_n);
                r_out.status <= w_full ? ST_FULL : ST_STORED;
            end
        end
    end

    assign o_res.valid = r_out_vld;
    assign o_res.data  = r_out;
endmodule

`default_nettype wire

// ===== design/plcb_checker.sv =====
// Port-level checks for particle_cell_list_binning, attached by bind.
// Depends on plcb_pkg and particle_cell_list_binning_assert.svh.
`default_nettype none
`include "particle_cell_list_binning_assert.svh"

module plcb_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input plcb_pkg::t_out_beat i_out_data
);
    import plcb_pkg::*;

    // A stalled result beat holds
    `PLCB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data))

    // Dropped outside the grid: coordinates and slot read zero
    `PLCB_ASSERT_NOW(a_outside_zero, i_clk, i_rst_n, i_out_valid && i_out_data.status == ST_OUTSIDE, i_out_data.cell_x == '0 && i_out_data.cell_y == '0 && i_out_data.cell_z == '0 && i_out_data.slot == '0)

    // Dropped on a full cell: no slot reported
    `PLCB_ASSERT_NOW(a_full_slot, i_clk, i_rst_n, i_out_valid && i_out_data.status == ST_FULL, i_out_data.slot == '0)

    // Count clearing follows reset: no beat taken right after it
    `PLCB_ASSERT_NEXT_RST(a_clear_after_rst, i_clk, !i_rst_n, !i_in_ready && !i_out_valid)
endmodule

bind particle_cell_list_binning plcb_checker u_plcb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_ready (i_bin.ready),
    .i_out_valid(o_res.valid),
    .i_out_ready(o_res.ready),
    .i_out_data (o_res.data)
);

`default_nettype wire
